FILE: src/svne_pkg.sv
package svne_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int POS_W        = 24;
    localparam int SUM_W        = 24;
    localparam int NRM_W        = 16;
    localparam int KIND_W       = 2;
    localparam int DIFF_W       = POS_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int CROSS_W      = PROD_W + 1;
    localparam int QDEPTH       = 2;
    localparam int ONE_Q14      = 16384;

    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRI  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [IDX_W-1:0]        vertex_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [IDX_W-1:0]        corner_a;
        logic [IDX_W-1:0]        corner_b;
        logic [IDX_W-1:0]        corner_c;
    } item_t;

    typedef struct packed {
        logic                      start;
        logic signed [CROSS_W-1:0] nx;
        logic signed [CROSS_W-1:0] ny;
        logic signed [CROSS_W-1:0] nz;
    } norm_in_t;

    typedef struct packed {
        logic                    done;
        logic signed [NRM_W-1:0] qx;
        logic signed [NRM_W-1:0] qy;
        logic signed [NRM_W-1:0] qz;
    } norm_out_t;

endpackage

FILE: src/svne_front.sv
module svne_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_face_reversed,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [svne_pkg::KIND_W-1:0]   s_kind,
    input  logic [svne_pkg::IDX_W-1:0]    s_vertex_index,
    input  logic signed [svne_pkg::POS_W-1:0] s_pos_x_in,
    input  logic signed [svne_pkg::POS_W-1:0] s_pos_y_in,
    input  logic signed [svne_pkg::POS_W-1:0] s_pos_z_in,
    input  logic [svne_pkg::IDX_W-1:0]    s_corner_a,
    input  logic [svne_pkg::IDX_W-1:0]    s_corner_b,
    input  logic [svne_pkg::IDX_W-1:0]    s_corner_c,
    input  logic                          q_pop,
    output svne_pkg::item_t               q_head,
    output logic                          q_empty
);
    import svne_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    logic              rev_reg;
    item_t             item_reg [QDEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              accept;
    item_t             in_item;

    assign cfg_ready = 1'b1;
    assign s_ready   = (count_reg != CNT_W'(QDEPTH));
    assign accept    = s_valid && s_ready;
    assign q_empty   = (count_reg == '0);
    assign q_head    = item_reg[rd_ptr_reg];

    // classify: a reversed face swaps corners b and c on the way in
    always_comb begin
        in_item.kind         = s_kind;
        in_item.vertex_index = s_vertex_index;
        in_item.pos_x        = s_pos_x_in;
        in_item.pos_y        = s_pos_y_in;
        in_item.pos_z        = s_pos_z_in;
        in_item.corner_a     = s_corner_a;
        in_item.corner_b     = rev_reg ? s_corner_c : s_corner_b;
        in_item.corner_c     = rev_reg ? s_corner_b : s_corner_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rev_reg    <= 1'b0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (cfg_valid) begin
                rev_reg <= cfg_face_reversed;
            end
            if (accept) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (accept && !q_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!accept && q_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: src/svne_norm.sv
module svne_norm (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  svne_pkg::norm_in_t   norm_in,
    output svne_pkg::norm_out_t  norm_out
);
    import svne_pkg::*;

    localparam int MAG_W  = CROSS_W - 1;
    localparam int SQI_W  = 30;
    localparam int ACC_W  = 2 * SQI_W + 2;
    localparam int RT_W   = ACC_W + 1;
    localparam int LEN_W  = SQI_W + 1;
    localparam int QB     = 15;
    localparam int DIV_W  = LEN_W + QB - 1;

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SHIFT = 3'd1;
    localparam logic [2:0] N_SQ    = 3'd2;
    localparam logic [2:0] N_ROOT  = 3'd3;
    localparam logic [2:0] N_DSET  = 3'd4;
    localparam logic [2:0] N_DIV   = 3'd5;
    localparam logic [2:0] N_DONE  = 3'd6;

    logic [2:0]              state_reg;
    logic [MAG_W-1:0]        mag_reg [3];
    logic [2:0]              neg_reg;
    logic [4:0]              cnt_reg;
    logic [1:0]              comp_reg;
    logic [2*SQI_W-1:0]      sq_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic [ACC_W-1:0]        v_reg;
    logic [RT_W-1:0]         res_reg;
    logic [RT_W-1:0]         bit_reg;
    logic [LEN_W-1:0]        len_reg;
    logic [DIV_W-1:0]        drem_reg;
    logic [DIV_W-1:0]        dvs_reg;
    logic [QB-1:0]           quo_reg;
    logic signed [NRM_W-1:0] q_reg [3];

    logic [CROSS_W-1:0]      abs_x, abs_y, abs_z;
    logic [RT_W-1:0]         root_try;
    logic                    root_ge;
    logic [RT_W-1:0]         root_res_next;
    logic                    div_ge;
    logic [QB-1:0]           quo_fin;
    logic [QB-1:0]           quo_clamp;
    logic signed [NRM_W-1:0] q_signed;

    assign abs_x = norm_in.nx[CROSS_W-1] ? CROSS_W'(-norm_in.nx) : CROSS_W'(norm_in.nx);
    assign abs_y = norm_in.ny[CROSS_W-1] ? CROSS_W'(-norm_in.ny) : CROSS_W'(norm_in.ny);
    assign abs_z = norm_in.nz[CROSS_W-1] ? CROSS_W'(-norm_in.nz) : CROSS_W'(norm_in.nz);

    assign root_try      = res_reg + bit_reg;
    assign root_ge       = ({1'b0, v_reg} >= root_try);
    assign root_res_next = root_ge ? (res_reg >> 1) + bit_reg : (res_reg >> 1);

    assign div_ge    = (drem_reg >= dvs_reg);
    assign quo_fin   = {quo_reg[QB-2:0], div_ge};
    assign quo_clamp = (quo_fin > QB'(ONE_Q14)) ? QB'(ONE_Q14) : quo_fin;
    assign q_signed  = neg_reg[0] ? -$signed({1'b0, quo_clamp}) : $signed({1'b0, quo_clamp});

    always_comb begin
        norm_out.done = (state_reg == N_DONE);
        norm_out.qx   = q_reg[0];
        norm_out.qy   = q_reg[1];
        norm_out.qz   = q_reg[2];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
        end else begin
            case (state_reg)
                N_IDLE: begin
                    if (norm_in.start) begin
                        if ((abs_x | abs_y | abs_z) == '0) begin
                            state_reg <= N_DONE;
                        end else begin
                            state_reg <= N_SHIFT;
                        end
                    end
                end
                N_SHIFT: begin
                    if ((mag_reg[0] | mag_reg[1] | mag_reg[2]) >> SQI_W == '0) begin
                        state_reg <= N_SQ;
                    end
                end
                N_SQ:   if (cnt_reg == 5'd3) state_reg <= N_ROOT;
                N_ROOT: if (cnt_reg == 5'd31) state_reg <= N_DSET;
                N_DSET: state_reg <= N_DIV;
                N_DIV: begin
                    if (cnt_reg == 5'(QB - 1)) begin
                        state_reg <= (comp_reg == 2'd2) ? N_DONE : N_DSET;
                    end
                end
                N_DONE:  state_reg <= N_IDLE;
                default: state_reg <= N_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            N_IDLE: begin
                mag_reg[0] <= abs_x[MAG_W-1:0];
                mag_reg[1] <= abs_y[MAG_W-1:0];
                mag_reg[2] <= abs_z[MAG_W-1:0];
                neg_reg    <= {norm_in.nz[CROSS_W-1], norm_in.ny[CROSS_W-1],
                               norm_in.nx[CROSS_W-1]};
                cnt_reg    <= '0;
                acc_reg    <= '0;
                comp_reg   <= '0;
                q_reg[0]   <= '0;
                q_reg[1]   <= '0;
                q_reg[2]   <= NRM_W'(ONE_Q14);
            end
            N_SHIFT: begin
                if ((mag_reg[0] | mag_reg[1] | mag_reg[2]) >> SQI_W != '0) begin
                    mag_reg[0] <= mag_reg[0] >> 1;
                    mag_reg[1] <= mag_reg[1] >> 1;
                    mag_reg[2] <= mag_reg[2] >> 1;
                end
            end
            N_SQ: begin
                // square one component a cycle, rotating the three through slot 0
                if (cnt_reg < 5'd3) begin
                    sq_reg     <= mag_reg[0][SQI_W-1:0] * mag_reg[0][SQI_W-1:0];
                    mag_reg[0] <= mag_reg[1];
                    mag_reg[1] <= mag_reg[2];
                    mag_reg[2] <= mag_reg[0];
                end
                if (cnt_reg != '0) begin
                    acc_reg <= acc_reg + ACC_W'(sq_reg);
                end
                if (cnt_reg == 5'd3) begin
                    v_reg   <= acc_reg + ACC_W'(sq_reg);
                    res_reg <= '0;
                    bit_reg <= {1'b1, {(RT_W-1){1'b0}}};
                    cnt_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            N_ROOT: begin
                if (root_ge) begin
                    v_reg <= ACC_W'({1'b0, v_reg} - root_try);
                end
                res_reg <= root_res_next;
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'd31) begin
                    len_reg <= (root_res_next[LEN_W-1:0] == '0) ? LEN_W'(1)
                                                              : root_res_next[LEN_W-1:0];
                end
            end
            N_DSET: begin
                drem_reg <= {mag_reg[0][SQI_W-1:0], {(QB-1){1'b0}}}
                            + DIV_W'(len_reg >> 1);
                dvs_reg  <= {len_reg, {(QB-1){1'b0}}};
                quo_reg  <= '0;
                cnt_reg  <= '0;
            end
            N_DIV: begin
                if (div_ge) begin
                    drem_reg <= drem_reg - dvs_reg;
                end
                dvs_reg <= dvs_reg >> 1;
                quo_reg <= quo_fin;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'(QB - 1)) begin
                    q_reg[0]   <= q_reg[1];
                    q_reg[1]   <= q_reg[2];
                    q_reg[2]   <= q_signed;
                    mag_reg[0] <= mag_reg[1];
                    mag_reg[1] <= mag_reg[2];
                    mag_reg[2] <= mag_reg[0];
                    neg_reg    <= {neg_reg[0], neg_reg[2:1]};
                    comp_reg   <= comp_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: src/svne_back.sv
module svne_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  svne_pkg::item_t               q_head,
    input  logic                          q_empty,
    output logic                          q_pop,
    output svne_pkg::norm_in_t            norm_in,
    input  svne_pkg::norm_out_t           norm_out,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [svne_pkg::NRM_W-1:0] m_normal_x,
    output logic signed [svne_pkg::NRM_W-1:0] m_normal_y,
    output logic signed [svne_pkg::NRM_W-1:0] m_normal_z
);
    import svne_pkg::*;

    localparam logic [3:0] B_IDLE     = 4'd0;
    localparam logic [3:0] B_TA       = 4'd1;
    localparam logic [3:0] B_TB       = 4'd2;
    localparam logic [3:0] B_TC       = 4'd3;
    localparam logic [3:0] B_TD       = 4'd4;
    localparam logic [3:0] B_MUL      = 4'd5;
    localparam logic [3:0] B_NSTART   = 4'd6;
    localparam logic [3:0] B_NWAIT    = 4'd7;
    localparam logic [3:0] B_RMW_WAIT = 4'd8;
    localparam logic [3:0] B_RMW_WR   = 4'd9;
    localparam logic [3:0] B_RD_WAIT  = 4'd10;
    localparam logic [3:0] B_RD_GO    = 4'd11;
    localparam logic [3:0] B_OUT      = 4'd12;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [NRM_W-1:0] b
    );
        logic signed [SUM_W:0] t;
        t = SUM_W'(0) + (SUM_W+1)'(a) + (SUM_W+1)'(b);
        if (t > $signed({2'b00, {(SUM_W-1){1'b1}}})) begin
            return {1'b0, {(SUM_W-1){1'b1}}};
        end else if (t < $signed({2'b11, {(SUM_W-1){1'b0}}})) begin
            return {1'b1, {(SUM_W-1){1'b0}}};
        end
        return t[SUM_W-1:0];
    endfunction

    logic signed [POS_W-1:0]   vx_mem [MAX_VERTICES];
    logic signed [POS_W-1:0]   vy_mem [MAX_VERTICES];
    logic signed [POS_W-1:0]   vz_mem [MAX_VERTICES];
    logic signed [SUM_W-1:0]   sx_mem [MAX_VERTICES];
    logic signed [SUM_W-1:0]   sy_mem [MAX_VERTICES];
    logic signed [SUM_W-1:0]   sz_mem [MAX_VERTICES];

    logic [3:0]                state_reg;
    logic [IDX_W-1:0]          addr_reg;
    logic [IDX_W-1:0]          ca_reg, cb_reg, cc_reg;
    logic [1:0]                corner_k_reg;
    logic                      is_read_reg;
    logic [2:0]                cnt_reg;
    logic signed [POS_W-1:0]   px_rd, py_rd, pz_rd;
    logic signed [SUM_W-1:0]   sx_rd, sy_rd, sz_rd;
    logic signed [POS_W-1:0]   pax_reg, pay_reg, paz_reg;
    logic signed [DIFF_W-1:0]  ux_reg, uy_reg, uz_reg;
    logic signed [DIFF_W-1:0]  wx_reg, wy_reg, wz_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [CROSS_W-1:0] n0_reg, n1_reg, n2_reg;
    logic signed [NRM_W-1:0]   qx_reg, qy_reg, qz_reg;
    logic                      m_valid_reg;
    logic signed [NRM_W-1:0]   ox_reg, oy_reg, oz_reg;

    logic signed [DIFF_W-1:0]  op1, op2;
    logic signed [CROSS_W-1:0] prod_ext;
    logic                      do_load;
    logic                      sum_we;
    logic [IDX_W-1:0]          sum_wa;
    logic signed [SUM_W-1:0]   sum_wx, sum_wy, sum_wz;
    logic [IDX_W-1:0]          next_corner;
    logic                      out_load;

    assign q_pop    = (state_reg == B_IDLE) && !q_empty;
    assign do_load  = q_pop && (q_head.kind == KIND_LOAD);
    assign prod_ext = {prod_reg[PROD_W-1], prod_reg};
    assign out_load = (state_reg == B_OUT) && (!m_valid_reg || m_ready);

    assign m_valid    = m_valid_reg;
    assign m_normal_x = ox_reg;
    assign m_normal_y = oy_reg;
    assign m_normal_z = oz_reg;

    always_comb begin
        norm_in.start = (state_reg == B_NSTART);
        norm_in.nx    = n0_reg;
        norm_in.ny    = n1_reg;
        norm_in.nz    = n2_reg;
    end

    always_comb begin
        case (cnt_reg)
            3'd0:    begin op1 = uy_reg; op2 = wz_reg; end
            3'd1:    begin op1 = uz_reg; op2 = wy_reg; end
            3'd2:    begin op1 = uz_reg; op2 = wx_reg; end
            3'd3:    begin op1 = ux_reg; op2 = wz_reg; end
            3'd4:    begin op1 = ux_reg; op2 = wy_reg; end
            default: begin op1 = uy_reg; op2 = wx_reg; end
        endcase
    end

    always_comb begin
        case (corner_k_reg)
            2'd0:    next_corner = cb_reg;
            default: next_corner = cc_reg;
        endcase
    end

    always_comb begin
        sum_we = do_load || (state_reg == B_RMW_WR);
        sum_wa = do_load ? q_head.vertex_index : addr_reg;
        if (do_load) begin
            sum_wx = '0;
            sum_wy = '0;
            sum_wz = '0;
        end else begin
            sum_wx = sat_add(sx_rd, qx_reg);
            sum_wy = sat_add(sy_rd, qy_reg);
            sum_wz = sat_add(sz_rd, qz_reg);
        end
    end

    // vertex and sum stores: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (do_load) begin
            vx_mem[q_head.vertex_index] <= q_head.pos_x;
            vy_mem[q_head.vertex_index] <= q_head.pos_y;
            vz_mem[q_head.vertex_index] <= q_head.pos_z;
        end
        if (sum_we) begin
            sx_mem[sum_wa] <= sum_wx;
            sy_mem[sum_wa] <= sum_wy;
            sz_mem[sum_wa] <= sum_wz;
        end
        px_rd <= vx_mem[addr_reg];
        py_rd <= vy_mem[addr_reg];
        pz_rd <= vz_mem[addr_reg];
        sx_rd <= sx_mem[addr_reg];
        sy_rd <= sy_mem[addr_reg];
        sz_rd <= sz_mem[addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end
            case (state_reg)
                B_IDLE: begin
                    if (q_pop) begin
                        if (q_head.kind == KIND_TRI) begin
                            state_reg <= B_TA;
                        end else if (q_head.kind == KIND_READ) begin
                            state_reg <= B_RD_WAIT;
                        end
                    end
                end
                B_TA:      state_reg <= B_TB;
                B_TB:      state_reg <= B_TC;
                B_TC:      state_reg <= B_TD;
                B_TD:      state_reg <= B_MUL;
                B_MUL:     if (cnt_reg == 3'd6) state_reg <= B_NSTART;
                B_NSTART:  state_reg <= B_NWAIT;
                B_NWAIT: begin
                    if (norm_out.done) begin
                        state_reg <= is_read_reg ? B_OUT : B_RMW_WAIT;
                    end
                end
                B_RMW_WAIT: state_reg <= B_RMW_WR;
                B_RMW_WR: begin
                    state_reg <= (corner_k_reg == 2'd2) ? B_IDLE : B_RMW_WAIT;
                end
                B_RD_WAIT: state_reg <= B_RD_GO;
                B_RD_GO:   state_reg <= B_NSTART;
                B_OUT:     if (out_load) state_reg <= B_IDLE;
                default:   state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            ox_reg <= qx_reg;
            oy_reg <= qy_reg;
            oz_reg <= qz_reg;
        end
        case (state_reg)
            B_IDLE: begin
                ca_reg      <= q_head.corner_a;
                cb_reg      <= q_head.corner_b;
                cc_reg      <= q_head.corner_c;
                is_read_reg <= (q_head.kind == KIND_READ);
                addr_reg    <= (q_head.kind == KIND_READ) ? q_head.vertex_index
                                                          : q_head.corner_a;
            end
            B_TA: addr_reg <= cb_reg;
            B_TB: begin
                pax_reg  <= px_rd;
                pay_reg  <= py_rd;
                paz_reg  <= pz_rd;
                addr_reg <= cc_reg;
            end
            B_TC: begin
                ux_reg <= DIFF_W'(px_rd) - DIFF_W'(pax_reg);
                uy_reg <= DIFF_W'(py_rd) - DIFF_W'(pay_reg);
                uz_reg <= DIFF_W'(pz_rd) - DIFF_W'(paz_reg);
            end
            B_TD: begin
                wx_reg  <= DIFF_W'(px_rd) - DIFF_W'(pax_reg);
                wy_reg  <= DIFF_W'(py_rd) - DIFF_W'(pay_reg);
                wz_reg  <= DIFF_W'(pz_rd) - DIFF_W'(paz_reg);
                cnt_reg <= '0;
            end
            B_MUL: begin
                // one product a cycle; fold the previous one into the cross product
                prod_reg <= op1 * op2;
                cnt_reg  <= cnt_reg + 1'b1;
                case (cnt_reg)
                    3'd1:    n0_reg <= prod_ext;
                    3'd2:    n0_reg <= n0_reg - prod_ext;
                    3'd3:    n1_reg <= prod_ext;
                    3'd4:    n1_reg <= n1_reg - prod_ext;
                    3'd5:    n2_reg <= prod_ext;
                    3'd6:    n2_reg <= n2_reg - prod_ext;
                    default: begin
                    end
                endcase
            end
            B_NWAIT: begin
                qx_reg       <= norm_out.qx;
                qy_reg       <= norm_out.qy;
                qz_reg       <= norm_out.qz;
                corner_k_reg <= '0;
                addr_reg     <= ca_reg;
            end
            B_RMW_WR: begin
                corner_k_reg <= corner_k_reg + 1'b1;
                addr_reg     <= next_corner;
            end
            B_RD_GO: begin
                n0_reg <= CROSS_W'(sx_rd);
                n1_reg <= CROSS_W'(sy_rd);
                n2_reg <= CROSS_W'(sz_rd);
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: src/smooth_vertex_normal_engine.sv
// Channel   Direction  Handshake              Payload
// -------   ---------  ---------------------  ------------------------------------------
// s_        in         s_valid / s_ready      kind, vertex_index, pos_x/y/z_in, corners
// m_        out        m_valid / m_ready      normal_x, normal_y, normal_z (Q1.14)
// cfg_      in         cfg_valid / cfg_ready  face_reversed
//
// A load item retires in the back end's idle state; reads and triangles also pass
// through the normalize unit, which takes a zero vector straight to done and else
// does up to 19 single-bit pre-shifts, squares the three components, takes 32
// square-root steps, runs three divides (setup plus 15 steps) and a done state.
// Synchronous active-low reset clears control only; the stores are undefined
// until written. A 2-entry queue sits between front and back, so input keeps
// flowing while the back end works or a result waits on m_ready, until it fills.
module smooth_vertex_normal_engine (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_face_reversed,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [svne_pkg::KIND_W-1:0]       s_kind,
    input  logic [svne_pkg::IDX_W-1:0]        s_vertex_index,
    input  logic signed [svne_pkg::POS_W-1:0] s_pos_x_in,
    input  logic signed [svne_pkg::POS_W-1:0] s_pos_y_in,
    input  logic signed [svne_pkg::POS_W-1:0] s_pos_z_in,
    input  logic [svne_pkg::IDX_W-1:0]        s_corner_a,
    input  logic [svne_pkg::IDX_W-1:0]        s_corner_b,
    input  logic [svne_pkg::IDX_W-1:0]        s_corner_c,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [svne_pkg::NRM_W-1:0] m_normal_x,
    output logic signed [svne_pkg::NRM_W-1:0] m_normal_y,
    output logic signed [svne_pkg::NRM_W-1:0] m_normal_z
);
    import svne_pkg::*;

    item_t     q_head;
    logic      q_empty;
    logic      q_pop;
    norm_in_t  norm_in;
    norm_out_t norm_out;

    // front: register the config bit, swap corners, queue items
    svne_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_face_reversed (cfg_face_reversed),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_vertex_index    (s_vertex_index),
        .s_pos_x_in        (s_pos_x_in),
        .s_pos_y_in        (s_pos_y_in),
        .s_pos_z_in        (s_pos_z_in),
        .s_corner_a        (s_corner_a),
        .s_corner_b        (s_corner_b),
        .s_corner_c        (s_corner_c),
        .q_pop             (q_pop),
        .q_head            (q_head),
        .q_empty           (q_empty)
    );

    // back: stores, cross product, sum updates, result register
    svne_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_head     (q_head),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .norm_in    (norm_in),
        .norm_out   (norm_out),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_normal_x (m_normal_x),
        .m_normal_y (m_normal_y),
        .m_normal_z (m_normal_z)
    );

    // shared iterative normalize unit
    svne_norm u_norm (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .norm_in  (norm_in),
        .norm_out (norm_out)
    );

    // never pop an empty queue
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    // normalize must not be restarted while it reports done
    a_no_start_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        norm_out.done |-> !norm_in.start)
        else $error("normalize restarted while done");

    // done never comes in the same cycle as a start
    a_start_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        norm_in.start |-> !norm_out.done)
        else $error("normalize done together with start");

    // delivered x and z components stay within unit range
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_normal_x <= 16'sd16384 && m_normal_x >= -16'sd16384 &&
                     m_normal_z <= 16'sd16384 && m_normal_z >= -16'sd16384))
        else $error("normal component out of range");

endmodule

FILE: verif/tb_smooth_vertex_normal_engine.sv
`timescale 1ns / 100ps

module tb_smooth_vertex_normal_engine;
    import svne_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    // margin for the triangle in the back end and two more that may sit in the queue
    localparam int SETTLE_CYCLES  = 500;
    localparam int POS_MAX = 8388607;
    localparam int POS_MIN = -8388608;

    typedef struct {
        logic signed [NRM_W-1:0] x;
        logic signed [NRM_W-1:0] y;
        logic signed [NRM_W-1:0] z;
    } normal_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_valid, cfg_ready, cfg_face_reversed;
    logic s_valid, s_ready;
    logic [KIND_W-1:0] s_kind;
    logic [IDX_W-1:0] s_vertex_index, s_corner_a, s_corner_b, s_corner_c;
    logic signed [POS_W-1:0] s_pos_x_in, s_pos_y_in, s_pos_z_in;
    logic m_valid, m_ready;
    logic signed [NRM_W-1:0] m_normal_x, m_normal_y, m_normal_z;

    smooth_vertex_normal_engine uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_face_reversed(cfg_face_reversed),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_vertex_index(s_vertex_index),
        .s_pos_x_in(s_pos_x_in), .s_pos_y_in(s_pos_y_in), .s_pos_z_in(s_pos_z_in),
        .s_corner_a(s_corner_a), .s_corner_b(s_corner_b), .s_corner_c(s_corner_c),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_normal_x(m_normal_x), .m_normal_y(m_normal_y), .m_normal_z(m_normal_z)
    );

    always #6 aclk = ~aclk;

    // shadow copy of the vertex and sum stores plus the orientation register
    logic signed [POS_W-1:0] pos_x_mem [MAX_VERTICES];
    logic signed [POS_W-1:0] pos_y_mem [MAX_VERTICES];
    logic signed [POS_W-1:0] pos_z_mem [MAX_VERTICES];
    int sum_x_mem [MAX_VERTICES];
    int sum_y_mem [MAX_VERTICES];
    int sum_z_mem [MAX_VERTICES];
    bit loaded [MAX_VERTICES];
    int loaded_list [$];
    bit flip_bc;

    normal_t pending_normals [$];
    int error_count = 0;
    int normals_checked = 0;
    int items_sent = 0;
    int tri_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles = 0;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // scale an integer vector to a Q1.14 unit vector; zero vector points up in z
    function automatic normal_t unit_vector(input longint nx, input longint ny, input longint nz);
        longint vec [3];
        longint unsigned mag [3];
        longint unsigned peak, len2, len, r;
        int sh;
        int q [3];
        normal_t res;
        vec[0] = nx; vec[1] = ny; vec[2] = nz;
        peak = 0;
        len2 = 0;
        sh = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = vec[i] < 0 ? longint'(-vec[i]) : longint'(vec[i]);
            if (mag[i] > peak) peak = mag[i];
        end
        if (peak == 0) begin
            res.x = '0; res.y = '0; res.z = NRM_W'(ONE_Q14);
            return res;
        end
        while ((peak >> sh) >= (64'd1 << 30)) sh++;
        for (int i = 0; i < 3; i++) begin
            mag[i] >>= sh;
            len2 += mag[i] * mag[i];
        end
        len = int_sqrt(len2);
        if (len == 0) len = 1;
        for (int i = 0; i < 3; i++) begin
            r = (mag[i] * ONE_Q14 + (len >> 1)) / len;
            if (r > ONE_Q14) r = ONE_Q14;
            q[i] = vec[i] < 0 ? -int'(r) : int'(r);
        end
        res.x = NRM_W'(q[0]); res.y = NRM_W'(q[1]); res.z = NRM_W'(q[2]);
        return res;
    endfunction

    function automatic int sat_sum(input int a, input int b);
        longint t;
        t = longint'(a) + longint'(b);
        if (t > POS_MAX) t = POS_MAX;
        if (t < POS_MIN) t = POS_MIN;
        return int'(t);
    endfunction

    // advance the shadow state by one accepted item; queue a normal for reads
    function automatic void predict_item(input logic [KIND_W-1:0] kind,
                                         input logic [IDX_W-1:0] vi,
                                         input logic signed [POS_W-1:0] px, py, pz,
                                         input logic [IDX_W-1:0] ca, cb, cc);
        longint ux, uy, uz, wx, wy, wz;
        logic [IDX_W-1:0] corner [3];
        logic [IDX_W-1:0] t;
        normal_t nrm;
        case (kind)
            KIND_LOAD: begin
                pos_x_mem[vi] = px; pos_y_mem[vi] = py; pos_z_mem[vi] = pz;
                sum_x_mem[vi] = 0; sum_y_mem[vi] = 0; sum_z_mem[vi] = 0;
            end
            KIND_TRI: begin
                if (flip_bc) begin
                    t = cb; cb = cc; cc = t;
                end
                ux = longint'(pos_x_mem[cb]) - longint'(pos_x_mem[ca]);
                uy = longint'(pos_y_mem[cb]) - longint'(pos_y_mem[ca]);
                uz = longint'(pos_z_mem[cb]) - longint'(pos_z_mem[ca]);
                wx = longint'(pos_x_mem[cc]) - longint'(pos_x_mem[ca]);
                wy = longint'(pos_y_mem[cc]) - longint'(pos_y_mem[ca]);
                wz = longint'(pos_z_mem[cc]) - longint'(pos_z_mem[ca]);
                nrm = unit_vector(uy * wz - uz * wy, uz * wx - ux * wz, ux * wy - uy * wx);
                corner[0] = ca; corner[1] = cb; corner[2] = cc;
                for (int k = 0; k < 3; k++) begin
                    sum_x_mem[corner[k]] = sat_sum(sum_x_mem[corner[k]], nrm.x);
                    sum_y_mem[corner[k]] = sat_sum(sum_y_mem[corner[k]], nrm.y);
                    sum_z_mem[corner[k]] = sat_sum(sum_z_mem[corner[k]], nrm.z);
                end
            end
            KIND_READ: begin
                nrm = unit_vector(sum_x_mem[vi], sum_y_mem[vi], sum_z_mem[vi]);
                pending_normals = {pending_normals, nrm};
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // compare every result transfer against the oldest pending normal
    always @(posedge aclk) begin
        normal_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_normals.size() == 0) begin
                report_mismatch("unexpected result, normal_x", m_normal_x, 0);
            end else begin
                want = pending_normals.pop_front();
                if (m_normal_x !== want.x) report_mismatch("normal_x", m_normal_x, want.x);
                if (m_normal_y !== want.y) report_mismatch("normal_y", m_normal_y, want.y);
                if (m_normal_z !== want.z) report_mismatch("normal_z", m_normal_z, want.z);
            end
            normals_checked++;
        end
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // end the run if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d normals pending", pending_normals.size());
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // present one item, hold it until the transfer, then update the prediction
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] vi,
                             input logic signed [POS_W-1:0] px, py, pz,
                             input logic [IDX_W-1:0] ca, cb, cc);
        @(negedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_vertex_index <= vi;
        s_pos_x_in <= px; s_pos_y_in <= py; s_pos_z_in <= pz;
        s_corner_a <= ca; s_corner_b <= cb; s_corner_c <= cc;
        do @(posedge aclk); while (!s_ready);
        predict_item(kind, vi, px, py, pz, ca, cb, cc);
        items_sent++;
        if (kind == KIND_TRI) tri_count++;
    endtask

    task automatic load_vertex(input int vi, input int px, input int py, input int pz);
        send_item(KIND_LOAD, IDX_W'(vi), POS_W'(px), POS_W'(py), POS_W'(pz),
                  IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
        if (!loaded[vi]) begin
            loaded[vi] = 1'b1;
            loaded_list = {loaded_list, vi};
        end
    endtask

    task automatic add_triangle(input int ca, input int cb, input int cc);
        send_item(KIND_TRI, IDX_W'($urandom), POS_W'($urandom), POS_W'($urandom),
                  POS_W'($urandom), IDX_W'(ca), IDX_W'(cb), IDX_W'(cc));
    endtask

    task automatic read_normal(input int vi);
        send_item(KIND_READ, IDX_W'(vi), POS_W'($urandom), POS_W'($urandom),
                  POS_W'($urandom), IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
    endtask

    task automatic send_unused(input int vi, input int px, input int ca);
        send_item(KIND_UNUSED, IDX_W'(vi), POS_W'(px), POS_W'(px), POS_W'(px),
                  IDX_W'(ca), IDX_W'(ca + 1), IDX_W'(ca + 2));
    endtask

    // drop valid and hold until every read has answered and the back end is idle
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_normals.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_orientation(input bit flip);
        wait_idle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_face_reversed <= flip;
        do @(posedge aclk); while (!cfg_ready);
        flip_bc = flip;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic int rand_pos();
        if ($urandom_range(1)) return $signed(24'($urandom));
        return $signed($urandom_range(4000)) - 2000;
    endfunction

    function automatic int pick_loaded();
        return loaded_list[$urandom_range(loaded_list.size() - 1)];
    endfunction

    task automatic test_directed();
        // extremes of the position range and of the vertex slots
        load_vertex(0, 0, 0, 0);
        load_vertex(1, 256, 0, 0);
        load_vertex(2, 0, 256, 0);
        load_vertex(1023, POS_MAX, POS_MIN, POS_MAX);
        load_vertex(1022, POS_MIN, POS_MAX, POS_MIN);
        load_vertex(3, POS_MIN, POS_MIN, POS_MAX);
        // a fresh vertex reads back as straight up
        read_normal(1023);
        // small right triangle, then the same one reversed
        add_triangle(0, 1, 2);
        read_normal(0);
        set_orientation(1'b1);
        add_triangle(0, 1, 2);
        read_normal(1);
        set_orientation(1'b0);
        // huge cross product forces the pre-shift
        add_triangle(1023, 1022, 3);
        read_normal(1023);
        read_normal(3);
        // repeated corners give the degenerate normal
        add_triangle(2, 2, 0);
        add_triangle(1, 1, 1);
        read_normal(2);
        // unused kind must be ignored with no result
        send_unused(1, 1, 0);
        send_unused(1023, -1, 1021);
        // reload clears the sum
        load_vertex(0, 0, 0, 0);
        read_normal(0);
    endtask

    task automatic test_saturation();
        load_vertex(10, 0, 0, 0);
        load_vertex(11, 0, 256, 0);
        load_vertex(12, 256, 0, 0);
        load_vertex(13, 5, 5, 5);
        // degenerate triangle adds +z three times per item: drive vertex 13 to the top
        for (int i = 0; i < 172; i++) add_triangle(13, 13, 13);
        read_normal(13);
        // normal -z on all three corners: drive them to the bottom
        for (int i = 0; i < 514; i++) add_triangle(10, 11, 12);
        read_normal(10);
        read_normal(12);
    endtask

    task automatic test_random(input int n_items);
        int roll, ca, cb, cc;
        for (int i = 0; i < n_items; i++) begin
            roll = $urandom_range(99);
            if (roll < 20 || loaded_list.size() < 3) begin
                load_vertex($urandom_range(MAX_VERTICES - 1), rand_pos(), rand_pos(), rand_pos());
            end else if (roll < 70) begin
                ca = pick_loaded(); cb = pick_loaded(); cc = pick_loaded();
                if ($urandom_range(9) == 0) cb = ca;
                add_triangle(ca, cb, cc);
            end else if (roll < 95) begin
                read_normal(pick_loaded());
            end else begin
                send_unused($urandom, $urandom, $urandom);
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_face_reversed = 1'b0;
        s_valid = 1'b0;
        s_kind = KIND_LOAD;
        s_vertex_index = '0;
        s_pos_x_in = '0; s_pos_y_in = '0; s_pos_z_in = '0;
        s_corner_a = '0; s_corner_b = '0; s_corner_c = '0;
        m_ready = 1'b0;
        flip_bc = 1'b0;
        foreach (loaded[i]) loaded[i] = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_orientation(1'b0);
        test_directed();
        test_saturation();

        // sender idles often less than the receiver
        send_idle_pct = 29; recv_idle_pct = 59;
        test_random(30);
        // sender holds off once until everything has come back
        wait_idle();
        test_random(10);
        set_orientation(1'b1);
        send_idle_pct = 59; recv_idle_pct = 29;
        test_random(30);
        set_orientation(1'b0);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(15);
        set_orientation(1'b1);
        test_random(10);

        wait_idle();
        $display("covered %0d items (%0d triangles), %0d normals checked, both orientations,",
                 items_sent, tri_count, normals_checked);
        $display("saturated sums, degenerate faces and idle mixes on both channels");
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
